// File: rtl/core/ppc_pkg.sv
// polyline path cursor: shared operation codes and field widths
// no dependencies; used by the top level and its checker
package ppc_pkg;

	localparam int OP_W  = 3;
	localparam int TAG_W = 8;
	localparam int FRAC_OUT_W = 17;
	localparam int MOVED_W = 32;

	localparam logic [OP_W-1:0] OP_LOAD    = 3'd0;
	localparam logic [OP_W-1:0] OP_CLEAR   = 3'd1;
	localparam logic [OP_W-1:0] OP_RESTART = 3'd2;
	localparam logic [OP_W-1:0] OP_ADVANCE = 3'd3;
	localparam logic [OP_W-1:0] OP_NEXT    = 3'd4;

endpackage

// File: rtl/core/ppc_mem.sv
// edge table memory: one write port, one read port, registered read data
// no dependencies; instantiated by polyline_path_cursor
module ppc_mem #(
	parameter int AW = 8,
	parameter int DW = 48
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/core/ppc_div.sv
// fraction step divider: floor(num * 2^FB / den), one quotient bit per cycle
// relies on the quotient never exceeding 2^FB; no package use
module ppc_div #(
	parameter int LB = 32,
	parameter int FB = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [31:0]   num,
	input  logic [LB-1:0] den,
	output logic          done,
	output logic [FB:0]   quot
);

	localparam int CW  = (LB > 32) ? LB : 32;
	localparam int NW  = $clog2(FB + 2);

	logic [CW-1:0] half;
	logic [LB-1:0] rem_q;
	logic [LB-1:0] den_q;
	logic          nb_q;
	logic [NW-1:0] cnt_q;
	logic          busy_q;
	logic [LB:0]   trial;
	logic          ge;

	assign half  = CW'(num >> 1);
	assign trial = {rem_q, nb_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= NW'(FB + 1);
				rem_q  <= half[LB-1:0];
				den_q  <= den;
				nb_q   <= num[0];
				quot   <= '0;
			end else if (busy_q) begin
				// remaining dividend bits after the first are zero
				nb_q  <= 1'b0;
				rem_q <= ge ? LB'(trial - {1'b0, den_q}) : trial[LB-1:0];
				quot  <= {quot[FB-1:0], ge};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == NW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

endmodule

// File: rtl/core/polyline_path_cursor.sv
// polyline path cursor top level: op sequencer, cursor registers, edge table
// depends on ppc_pkg, ppc_mem, ppc_div
// load, clear, restart, next waypoint: the result goes through S_TAG and S_OUT, then is registered
// advance: S_RD, S_MUL and S_CMP for each edge visited, then S_DIV for the final divide
// one item at a time; the next input beat is taken once the result is registered
// arst_n clears the path, tag counters and cursor; the edge table is not cleared
module polyline_path_cursor #(
	parameter int MAX_EDGES = 256,
	parameter int FRACTION_BITS = 16,
	parameter int LENGTH_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  operation,
	input  logic [31:0] edge_length,
	input  logic        starts_segment,
	input  logic [31:0] distance,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        ok,
	output logic        at_end,
	output logic [31:0] moved,
	output logic [7:0]  segment_number,
	output logic [7:0]  waypoint_number,
	output logic [16:0] fraction
);

	localparam int AW   = $clog2(MAX_EDGES);
	localparam int CNTW = $clog2(MAX_EDGES + 1);
	localparam int LB   = LENGTH_BITS;
	localparam int FB   = FRACTION_BITS;
	localparam int FW   = FB + 1;
	localparam int TW   = ppc_pkg::TAG_W;
	localparam int DW   = LB + 2 * TW;
	localparam int CW   = ((LB > 32) ? LB : 32) + 1;
	localparam int XW   = (LB > 32) ? LB : 32;
	localparam int FXW  = (FW > 17) ? FW : 17;
	localparam int HW   = LB - FB + FW;
	localparam int LW   = FB + FW;
	localparam logic [FW-1:0] ONE = FW'(1) << FB;

	typedef enum logic [2:0] {S_IDLE, S_RD, S_MUL, S_CMP, S_DIV, S_TAG, S_OUT} state_t;

	state_t          state_q;
	logic [CNTW-1:0] loaded_q;
	logic [TW-1:0]   seg_q, wp_q;
	logic [AW-1:0]   cur_edge_q;
	logic [FW-1:0]   cur_frac_q;
	logic            end_q;
	logic            ok_q;
	logic [31:0]     moved_q;

	// walk registers
	logic [CNTW-1:0] e_q;
	logic [FW-1:0]   frac_q;
	logic [31:0]     left_q, dist_q, acc_q;
	logic [LB-1:0]   len_q;
	logic [HW-1:0]   hi_prod_q;
	logic [LW-1:0]   lo_prod_q;

	logic            accept, full, bump, mem_we, div_start, div_done, out_load;
	logic [TW-1:0]   seg_new, wp_new;
	logic [XW-1:0]   elen_ext;
	logic [AW-1:0]   raddr;
	logic [DW-1:0]   wdata, rdata;
	logic [LB-1:0]   rd_len;
	logic [FW-1:0]   w;
	logic [LB:0]     rest_sum;
	logic            rest_lt;
	logic [FB:0]     quot;
	logic [FW:0]     frac_sum;
	logic [FXW-1:0]  frac_ext;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign full     = (loaded_q == CNTW'(MAX_EDGES));
	assign bump     = starts_segment && (loaded_q != '0);
	assign seg_new  = bump ? seg_q + 1'b1 : seg_q;
	assign wp_new   = bump ? '0 : wp_q;
	assign elen_ext = XW'(edge_length);
	assign mem_we   = accept && (operation == ppc_pkg::OP_LOAD) && !full;
	assign wdata    = {elen_ext[LB-1:0], seg_new, wp_new};
	assign raddr    = (state_q == S_RD) ? e_q[AW-1:0] : cur_edge_q;
	assign rd_len   = rdata[DW-1 -: LB];
	assign w        = ONE - frac_q;
	assign out_load = (state_q == S_OUT) && (!out_valid || out_ready);

	assign rest_sum  = (LB+1)'(hi_prod_q) + (LB+1)'(lo_prod_q >> FB);
	assign rest_lt   = CW'(rest_sum) < CW'(left_q);
	assign div_start = (state_q == S_CMP) && !rest_lt && (len_q != '0);
	assign frac_sum  = {1'b0, frac_q} + {1'b0, quot};
	assign frac_ext  = FXW'(cur_frac_q);

	ppc_mem #(.AW(AW), .DW(DW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (AW'(loaded_q)),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	ppc_div #(.LB(LB), .FB(FB)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (left_q),
		.den    (len_q),
		.done   (div_done),
		.quot   (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			loaded_q        <= '0;
			seg_q           <= '0;
			wp_q            <= '0;
			cur_edge_q      <= '0;
			cur_frac_q      <= '0;
			end_q           <= 1'b0;
			ok_q            <= 1'b0;
			moved_q         <= '0;
			out_valid       <= 1'b0;
			ok              <= 1'b0;
			at_end          <= 1'b0;
			moved           <= '0;
			fraction        <= '0;
			segment_number  <= '0;
			waypoint_number <= '0;
		end else begin
			if (out_valid && out_ready && !out_load) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_TAG;
						ok_q    <= 1'b0;
						moved_q <= '0;
						unique case (operation)
							ppc_pkg::OP_LOAD: begin
								if (!full) begin
									seg_q    <= seg_new;
									wp_q     <= wp_new + 1'b1;
									loaded_q <= loaded_q + 1'b1;
									ok_q     <= 1'b1;
								end
							end
							ppc_pkg::OP_CLEAR: begin
								loaded_q   <= '0;
								seg_q      <= '0;
								wp_q       <= '0;
								cur_edge_q <= '0;
								cur_frac_q <= '0;
								end_q      <= 1'b0;
								ok_q       <= 1'b1;
							end
							ppc_pkg::OP_RESTART: begin
								cur_edge_q <= '0;
								cur_frac_q <= '0;
								end_q      <= 1'b0;
								ok_q       <= (loaded_q != '0);
							end
							ppc_pkg::OP_ADVANCE: begin
								if (loaded_q != '0 && !end_q) begin
									if (distance == '0) begin
										ok_q <= 1'b1;
									end else begin
										state_q <= S_RD;
										e_q     <= CNTW'(cur_edge_q);
										frac_q  <= (cur_frac_q > ONE) ? ONE : cur_frac_q;
										left_q  <= distance;
										dist_q  <= distance;
										acc_q   <= '0;
									end
								end
							end
							ppc_pkg::OP_NEXT: begin
								if (loaded_q != '0) begin
									cur_frac_q <= '0;
									if (CNTW'(cur_edge_q) + 1'b1 >= loaded_q) begin
										cur_edge_q <= AW'(loaded_q - 1'b1);
										cur_frac_q <= ONE;
										end_q      <= 1'b1;
									end else begin
										cur_edge_q <= cur_edge_q + 1'b1;
										ok_q       <= 1'b1;
									end
								end
							end
							default: begin
								ok_q <= 1'b0;
							end
						endcase
					end
				end
				S_RD: begin
					if (e_q < loaded_q) begin
						state_q <= S_MUL;
					end else begin
						// ran off the path: park on the last edge
						cur_edge_q <= AW'(loaded_q - 1'b1);
						cur_frac_q <= ONE;
						end_q      <= 1'b1;
						ok_q       <= 1'b0;
						moved_q    <= acc_q;
						state_q    <= S_TAG;
					end
				end
				S_MUL: begin
					len_q     <= rd_len;
					hi_prod_q <= HW'(rd_len >> FB) * HW'(w);
					lo_prod_q <= LW'(rd_len[FB-1:0]) * LW'(w);
					state_q   <= S_CMP;
				end
				S_CMP: begin
					if (rest_lt) begin
						acc_q   <= acc_q + 32'(rest_sum);
						left_q  <= left_q - 32'(rest_sum);
						frac_q  <= '0;
						e_q     <= e_q + 1'b1;
						state_q <= S_RD;
					end else if (len_q == '0) begin
						cur_edge_q <= e_q[AW-1:0];
						cur_frac_q <= ONE;
						end_q      <= 1'b0;
						ok_q       <= 1'b1;
						moved_q    <= dist_q;
						state_q    <= S_TAG;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						cur_edge_q <= e_q[AW-1:0];
						cur_frac_q <= (frac_sum > (FW+1)'(ONE)) ? ONE : frac_sum[FW-1:0];
						end_q      <= 1'b0;
						ok_q       <= 1'b1;
						moved_q    <= dist_q;
						state_q    <= S_TAG;
					end
				end
				S_TAG: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						out_valid       <= 1'b1;
						ok              <= ok_q;
						at_end          <= end_q;
						moved           <= moved_q;
						fraction        <= frac_ext[16:0];
						segment_number  <= (loaded_q != '0) ? rdata[2*TW-1:TW] : '0;
						waypoint_number <= (loaded_q != '0) ? rdata[TW-1:0] : '0;
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/core/ppc_checker.sv
// port-level checker for polyline_path_cursor, bound to the top level
// depends on ppc_pkg
module ppc_checker #(
	parameter int FRACTION_BITS = 16
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        at_end,
	input logic [31:0] moved,
	input logic [16:0] fraction
);

	localparam logic [ppc_pkg::FRAC_OUT_W-1:0] ONE_OUT =
		ppc_pkg::FRAC_OUT_W'(64'd1 << FRACTION_BITS);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(moved) && $stable(fraction))
		else $error("result beat changed while stalled");

	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in work");

	a_end_frac_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && at_end |-> fraction == ONE_OUT)
		else $error("parked cursor without full fraction");

	a_no_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
		else $error("result appeared too early");

endmodule

bind polyline_path_cursor ppc_checker #(.FRACTION_BITS(FRACTION_BITS)) u_ppc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.at_end    (at_end),
	.moved     (moved),
	.fraction  (fraction)
);

// File: verif/polyline_path_cursor_tb.sv
// testbench for polyline_path_cursor: directed and random operations against a cursor model
// depends on ppc_pkg and the polyline_path_cursor rtl
module polyline_path_cursor_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int EDGE_CAP = 256;
	localparam logic [16:0] FRAC_ONE = 17'h10000;
	localparam longint CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic        ok;
		logic        at_end;
		logic [31:0] moved;
		logic [7:0]  seg;
		logic [7:0]  wp;
		logic [16:0] frac;
	} cursor_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] operation = ppc_pkg::OP_LOAD;
	logic [31:0] edge_length = '0;
	logic starts_segment = 1'b0;
	logic [31:0] distance = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic ok, at_end;
	logic [31:0] moved;
	logic [7:0] segment_number, waypoint_number;
	logic [16:0] fraction;

	polyline_path_cursor uut (.*);

	always #5 clk = ~clk;

	// cursor model state
	logic [31:0] edge_len_tab [EDGE_CAP];
	logic [7:0]  seg_tag_tab [EDGE_CAP];
	logic [7:0]  wp_tag_tab [EDGE_CAP];
	int unsigned n_edges;
	logic [7:0]  seg_count, wp_count;
	int unsigned cur_edge;
	logic [16:0] cur_frac;
	logic        parked;

	cursor_result_t expected_results[$];
	int unsigned mismatch_count = 0;
	longint cycle_count = 0;
	int unsigned gap_left = 0, burst_left = 0;

	function automatic longint unsigned edge_remainder(logic [31:0] len, longint unsigned w);
		return (longint'(len >> 16) * w) + ((longint'(len & 32'hFFFF) * w) >> 16);
	endfunction

	function automatic void park_cursor();
		cur_edge = n_edges - 1;
		cur_frac = FRAC_ONE;
		parked = 1'b1;
	endfunction

	function automatic cursor_result_t apply_operation(logic [2:0] op, logic [31:0] len,
			logic starts, logic [31:0] travel);
		cursor_result_t r;
		longint unsigned walked, left, rest, fr, stepv;
		int unsigned e;
		logic done;
		r = '0;
		case (op)
			ppc_pkg::OP_LOAD: begin
				if (n_edges < EDGE_CAP) begin
					if (starts && n_edges > 0) begin
						seg_count++;
						wp_count = '0;
					end
					edge_len_tab[n_edges] = len;
					seg_tag_tab[n_edges] = seg_count;
					wp_tag_tab[n_edges] = wp_count;
					wp_count++;
					n_edges++;
					r.ok = 1'b1;
				end
			end
			ppc_pkg::OP_CLEAR: begin
				n_edges = 0; seg_count = '0; wp_count = '0;
				cur_edge = 0; cur_frac = '0; parked = 1'b0;
				r.ok = 1'b1;
			end
			ppc_pkg::OP_RESTART: begin
				cur_edge = 0; cur_frac = '0; parked = 1'b0;
				r.ok = n_edges > 0;
			end
			ppc_pkg::OP_ADVANCE: begin
				if (n_edges == 0 || parked) r.ok = 1'b0;
				else if (travel == 0) r.ok = 1'b1;
				else begin
					walked = 0; left = travel; e = cur_edge; fr = cur_frac; done = 1'b0;
					while (e < n_edges && !done) begin
						rest = edge_remainder(edge_len_tab[e], 65536 - fr);
						if (walked + rest < travel) begin
							walked += rest; left -= rest; fr = 0; e++;
						end else begin
							stepv = edge_len_tab[e] != 0 ? (left * 65536) / edge_len_tab[e] : 65536;
							fr += stepv;
							if (fr > 65536) fr = 65536;
							cur_edge = e; cur_frac = fr[16:0]; parked = 1'b0;
							done = 1'b1;
						end
					end
					if (done) begin
						r.ok = 1'b1; r.moved = travel;
					end else begin
						park_cursor();
						r.moved = walked[31:0];
					end
				end
			end
			ppc_pkg::OP_NEXT: begin
				if (n_edges > 0) begin
					cur_frac = '0;
					cur_edge++;
					if (cur_edge >= n_edges) park_cursor();
					else r.ok = 1'b1;
				end
			end
			default: ;
		endcase
		r.at_end = parked;
		if (n_edges > 0 && cur_edge < n_edges) begin
			r.seg = seg_tag_tab[cur_edge];
			r.wp = wp_tag_tab[cur_edge];
		end
		r.frac = cur_frac;
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	// send one beat, with bursty gaps before it
	task automatic send_op(logic [2:0] op, logic [31:0] len = '0, logic starts = 1'b0,
			logic [31:0] travel = '0);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
		end
		repeat (gap_left) @(posedge clk);
		gap_left = 0;
		burst_left--;
		expected_results.push_back(apply_operation(op, len, starts, travel));
		in_valid <= 1'b1;
		operation <= op;
		edge_length <= len;
		starts_segment <= starts;
		distance <= travel;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		in_valid <= 1'b0;
		// the block is busy for a while after a beat anyway
		@(posedge clk);
	endtask

	// receiver stall pattern: long runs open, random stalls otherwise
	always @(posedge clk) begin
		if (cycle_count[9:8] == 2'b11) out_ready <= 1'b1;
		else out_ready <= ($urandom_range(0, 3) != 0);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		cursor_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) report_mismatch("unexpected beat", 1, 0);
			else begin
				want = expected_results.pop_front();
				if (ok !== want.ok) report_mismatch("ok", ok, want.ok);
				if (at_end !== want.at_end) report_mismatch("at_end", at_end, want.at_end);
				if (moved !== want.moved) report_mismatch("moved", moved, want.moved);
				if (segment_number !== want.seg)
					report_mismatch("segment_number", segment_number, want.seg);
				if (waypoint_number !== want.wp)
					report_mismatch("waypoint_number", waypoint_number, want.wp);
				if (fraction !== want.frac) report_mismatch("fraction", fraction, want.frac);
			end
		end
	end

	function automatic logic [31:0] rand_length();
		case ($urandom_range(0, 5))
			0: return 32'h0;
			1: return $urandom;
			2: return 32'hFFFFFFFF;
			default: return $urandom_range(1, 32'h4000);
		endcase
	endfunction

	task automatic test_empty_path();
		send_op(ppc_pkg::OP_ADVANCE, '0, 1'b0, 32'd100);
		send_op(ppc_pkg::OP_NEXT);
		send_op(ppc_pkg::OP_RESTART);
		send_op(3'd5);
		send_op(3'd7, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF);
		send_op(ppc_pkg::OP_CLEAR);
	endtask

	task automatic test_directed_walk();
		send_op(ppc_pkg::OP_LOAD, 32'h100, 1'b1);
		send_op(ppc_pkg::OP_LOAD, 32'h0, 1'b0);
		send_op(ppc_pkg::OP_LOAD, 32'hFFFFFFFF, 1'b1);
		send_op(ppc_pkg::OP_LOAD, 32'h300, 1'b0);
		send_op(ppc_pkg::OP_ADVANCE, '0, 1'b0, 32'h0);
		send_op(ppc_pkg::OP_ADVANCE, '0, 1'b0, 32'h80);
		send_op(ppc_pkg::OP_ADVANCE, '0, 1'b0, 32'h80);
		send_op(ppc_pkg::OP_ADVANCE, '0, 1'b0, 32'h1);
		send_op(ppc_pkg::OP_NEXT);
		send_op(ppc_pkg::OP_ADVANCE, '0, 1'b0, 32'hFFFFFFFF);
		send_op(ppc_pkg::OP_ADVANCE, '0, 1'b0, 32'hFFFFFFFF);
		send_op(ppc_pkg::OP_ADVANCE, '0, 1'b0, 32'h5);
		send_op(ppc_pkg::OP_RESTART);
		send_op(ppc_pkg::OP_NEXT); send_op(ppc_pkg::OP_NEXT);
		send_op(ppc_pkg::OP_NEXT); send_op(ppc_pkg::OP_NEXT);
		send_op(ppc_pkg::OP_CLEAR);
	endtask

	// fill the table to the limit and beyond; segment tags climb to 255 without wrapping
	task automatic test_full_table();
		for (int i = 0; i < EDGE_CAP + 2; i++)
			send_op(ppc_pkg::OP_LOAD, rand_length(), 1'b1);
		send_op(ppc_pkg::OP_ADVANCE, '0, 1'b0, 32'hFFFFFFFF);
		send_op(ppc_pkg::OP_RESTART);
		send_op(ppc_pkg::OP_ADVANCE, '0, 1'b0, $urandom);
		send_op(ppc_pkg::OP_CLEAR);
	endtask

	task automatic test_random_paths();
		int unsigned count;
		int unsigned n;
		count = 0;
		while (count < 850) begin
			if ($urandom_range(0, 9) != 0) send_op(ppc_pkg::OP_CLEAR);
			n = $urandom_range(1, 12);
			for (int i = 0; i < n; i++)
				send_op(ppc_pkg::OP_LOAD, rand_length(), $urandom_range(0, 2) == 0);
			count += n + 1;
			for (int i = 0; i < $urandom_range(2, 10); i++) begin
				case ($urandom_range(0, 9))
					0: send_op(ppc_pkg::OP_RESTART);
					1, 2: send_op(ppc_pkg::OP_NEXT);
					3: send_op(3'($urandom_range(0, 7)), $urandom, $urandom_range(0, 1),
						$urandom);
					4: send_op(ppc_pkg::OP_ADVANCE, '0, 1'b0, $urandom);
					default: send_op(ppc_pkg::OP_ADVANCE, '0, 1'b0,
						$urandom_range(0, 32'h3000));
				endcase
				count++;
			end
		end
	endtask

	initial begin
		n_edges = 0; seg_count = '0; wp_count = '0;
		cur_edge = 0; cur_frac = '0; parked = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_path();
		test_directed_walk();
		test_full_table();
		test_random_paths();
		while (expected_results.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end
endmodule

// File: files.f
rtl/core/ppc_pkg.sv
rtl/core/ppc_mem.sv
rtl/core/ppc_div.sv
rtl/core/polyline_path_cursor.sv
rtl/core/ppc_checker.sv
verif/polyline_path_cursor_tb.sv
